// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the assertions of the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bbst_pkg.sv =====
// Package for the size table unit: field widths, codes and helper functions.
`default_nettype none

package bbst_pkg;

  localparam int DEF_ADDR_BITS = 20;
  localparam int DEF_SLOT_BITS = 4;

  localparam int ADDR_W    = 20;
  localparam int COUNT_W   = 21;
  localparam int ENTRY_W   = 6;
  localparam int META_W    = 7;
  localparam int TOTAL_W   = 22;
  localparam int STATUS_W  = 2;
  localparam int MODE_W    = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [META_W-1:0] META_RESET = 7'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_REGISTER   = 2'd0,
    MODE_UNREGISTER = 2'd1,
    MODE_READ       = 2'd2,
    MODE_WRITE      = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE       = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_MISALIGNED = 2'd2,
    STAT_TOO_LARGE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_LOOKUP,
    S_FILL,
    S_RESP
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_EVAL,
    CMD_CHECK,
    CMD_READ,
    CMD_LOOKUP,
    CMD_FILL,
    CMD_WRITE,
    CMD_RESULT
  } dp_cmd_e;

  typedef struct packed {
    mode_e mode;
    logic  reg_ok;
    logic  entry_nz;
    logic  idx_last;
  } dp_status_t;

  // Smallest s with 2^s >= v, for v >= 1.
  function automatic logic [ENTRY_W-1:0] ceil_log2(input logic [TOTAL_W-1:0] v);
    logic [TOTAL_W-1:0] m;
    logic [ENTRY_W-1:0] r;
    m = v - TOTAL_W'(1);
    r = '0;
    for (int i = 0; i < TOTAL_W; i++) begin
      if (m[i]) r = ENTRY_W'(i + 1);
    end
    return r;
  endfunction

  // Low n bits set, within the address field.
  function automatic logic [ADDR_W-1:0] low_mask(input int n);
    return ADDR_W'((64'd1 << n) - 64'd1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bbst_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module bbst_ram #(
  parameter int WIDTH      = 6,
  parameter int DEPTH_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [DEPTH_BITS-1:0] addr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  output logic      [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem [2**DEPTH_BITS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bbst_datapath.sv =====
// Datapath: item registers, size computation, table RAM, index counter, result.
`default_nettype none

module bbst_datapath import bbst_pkg::*; #(
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int SLOT_BITS = DEF_SLOT_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_e             cmd_i,
  output dp_status_t               status_o,
  input  wire logic                cfg_we_i,
  input  wire logic [META_W-1:0]   cfg_wdata_i,
  input  wire logic [MODE_W-1:0]   in_mode_i,
  input  wire logic [ADDR_W-1:0]   in_address_i,
  input  wire logic [COUNT_W-1:0]  in_byte_count_i,
  input  wire logic [ENTRY_W-1:0]  in_entry_data_i,
  output logic      [STATUS_W-1:0] out_status_o,
  output logic      [ENTRY_W-1:0]  out_size_log2_o,
  output logic      [ADDR_W-1:0]   out_object_base_o
);

  localparam int IdxW = ADDR_BITS - SLOT_BITS;
  localparam logic [ADDR_W-1:0] AddrMask =
    (ADDR_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [META_W-1:0]  meta_q;
  logic [IdxW-1:0]    idx_q, span_q;
  mode_e              mode_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               zero_q;
  logic [TOTAL_W-1:0] total_q;
  logic [ENTRY_W-1:0] data_q, s_q, fill_val_q;
  status_e            res_status_q, out_status_q;
  logic [ENTRY_W-1:0] res_slog_q, out_slog_q;
  logic [ADDR_W-1:0]  res_base_q, out_base_q;

  logic [ADDR_W-1:0]  addr_m;
  logic [ENTRY_W-1:0] clog, e, ec;
  logic [ADDR_W-1:0]  base_s, base_e;
  logic [IdxW-1:0]    slot_idx, first_s, first_e, span_s, span_e;
  logic               too_large, reg_ok, entry_nz;
  status_e            reg_status;
  logic               ram_we;
  logic [IdxW-1:0]    ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign addr_m = in_address_i & AddrMask;
  assign clog   = ceil_log2(total_q);

  // Register path, from the stored log2 size.
  assign too_large = int'(s_q) > ADDR_BITS;
  assign base_s    = addr_q & ~low_mask(int'(s_q)) & AddrMask;
  assign first_s   = IdxW'(64'(base_s) >> SLOT_BITS);
  assign span_s    = IdxW'((64'd1 << (int'(s_q) - SLOT_BITS)) - 64'd1);

  always_comb begin
    priority if (zero_q) reg_status = STAT_EMPTY;
    else if (too_large)  reg_status = STAT_TOO_LARGE;
    else if (base_s != addr_q) reg_status = STAT_MISALIGNED;
    else reg_status = STAT_DONE;
  end
  assign reg_ok = (reg_status == STAT_DONE);

  // Lookup path, from the entry read out of the table.
  assign e        = ram_rdata;
  assign entry_nz = (e != '0);
  always_comb begin
    priority if (int'(e) < SLOT_BITS) ec = ENTRY_W'(SLOT_BITS);
    else if (int'(e) > ADDR_BITS)    ec = ENTRY_W'(ADDR_BITS);
    else ec = e;
  end
  assign base_e  = addr_q & ~low_mask(int'(ec)) & AddrMask;
  assign first_e = IdxW'(64'(base_e) >> SLOT_BITS);
  assign span_e  = IdxW'((64'd1 << (int'(ec) - SLOT_BITS)) - 64'd1);

  assign slot_idx = IdxW'(64'(addr_q) >> SLOT_BITS);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_idx;
    ram_wdata = data_q;
    unique case (cmd_i)
      CMD_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q;
        ram_wdata = '0;
      end
      CMD_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q;
        ram_wdata = fill_val_q;
      end
      CMD_WRITE: ram_we = 1'b1;
      default: ;
    endcase
  end

  bbst_ram #(
    .WIDTH      (ENTRY_W),
    .DEPTH_BITS (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Control state: config register and sweep counter. span all ones runs the clear pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= META_RESET;
      idx_q  <= '0;
      span_q <= '1;
    end else begin
      if (cfg_we_i) meta_q <= cfg_wdata_i;
      unique case (cmd_i)
        CMD_CLEAR, CMD_FILL: idx_q <= idx_q + IdxW'(1);
        CMD_CHECK: begin
          idx_q  <= first_s;
          span_q <= span_s;
        end
        CMD_LOOKUP: begin
          idx_q  <= first_e;
          span_q <= span_e;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        mode_q  <= mode_e'(in_mode_i);
        addr_q  <= addr_m;
        zero_q  <= (in_byte_count_i == '0) || (addr_m == '0);
        total_q <= TOTAL_W'(in_byte_count_i) + TOTAL_W'(meta_q);
        data_q  <= in_entry_data_i;
      end
      CMD_EVAL: s_q <= (int'(clog) < SLOT_BITS) ? ENTRY_W'(SLOT_BITS) : clog;
      CMD_CHECK: begin
        res_status_q <= reg_status;
        fill_val_q   <= s_q;
        unique case (reg_status)
          STAT_EMPTY: begin
            res_slog_q <= '0;
            res_base_q <= '0;
          end
          STAT_TOO_LARGE: begin
            res_slog_q <= s_q;
            res_base_q <= '0;
          end
          default: begin
            res_slog_q <= s_q;
            res_base_q <= base_s;
          end
        endcase
      end
      CMD_LOOKUP: begin
        fill_val_q <= '0;
        if (entry_nz) begin
          res_status_q <= STAT_DONE;
          res_slog_q   <= e;
          res_base_q   <= base_e;
        end else begin
          res_status_q <= STAT_EMPTY;
          res_slog_q   <= '0;
          res_base_q   <= '0;
        end
      end
      CMD_WRITE: begin
        res_status_q <= STAT_DONE;
        res_slog_q   <= data_q;
        res_base_q   <= addr_q & ~low_mask(SLOT_BITS);
      end
      CMD_RESULT: begin
        out_status_q <= res_status_q;
        out_slog_q   <= res_slog_q;
        out_base_q   <= res_base_q;
      end
      default: ;
    endcase
  end

  assign status_o.mode     = mode_q;
  assign status_o.reg_ok   = reg_ok;
  assign status_o.entry_nz = entry_nz;
  assign status_o.idx_last = ((idx_q & span_q) == span_q);

  assign out_status_o      = out_status_q;
  assign out_size_log2_o   = out_slog_q;
  assign out_object_base_o = out_base_q;

endmodule

`default_nettype wire

// ===== hdl/bbst_ctrl.sv =====
// Controller: sequences clear pass, dispatch, table sweeps and result handoff.
`default_nettype none

module bbst_ctrl import bbst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output dp_cmd_e         cmd_o,
  input  wire dp_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.idx_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.mode)
          MODE_REGISTER: begin
            cmd_o   = CMD_EVAL;
            state_d = S_CHECK;
          end
          MODE_UNREGISTER, MODE_READ: begin
            cmd_o   = CMD_READ;
            state_d = S_LOOKUP;
          end
          MODE_WRITE: begin
            cmd_o   = CMD_WRITE;
            state_d = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_CHECK: begin
        cmd_o   = CMD_CHECK;
        state_d = status_i.reg_ok ? S_FILL : S_RESP;
      end
      S_LOOKUP: begin
        cmd_o   = CMD_LOOKUP;
        state_d = (status_i.entry_nz && status_i.mode == MODE_UNREGISTER) ? S_FILL : S_RESP;
      end
      S_FILL: begin
        cmd_o = CMD_FILL;
        if (status_i.idx_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/baggy_bounds_size_table_unit.sv =====
// Top level of the baggy bounds size table unit.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tuser mode, tdata address/count/entry
//   m_axis    out  m_axis_tvalid / m_axis_tready  tuser status, tdata size/base
//   cfg       in   cfg_we_i                       cfg_wdata_i metadata_bytes
//
// Register: when the object is written, 2^(s-SLOT_BITS) table slots are written,
// one table slot per cycle.
// Unregister: 2^(e-SLOT_BITS) slots are cleared for a nonzero entry, e clamped to SLOT_BITS..ADDR_BITS.
// Reset runs a clearing pass over all 2^(ADDR_BITS-SLOT_BITS) table slots (65536 by default);
// no request is taken during it.
// A request is taken while a previous result still waits on m_axis; the block stalls
// only when a new result is ready and the output register is still full.
`default_nettype none

module baggy_bounds_size_table_unit import bbst_pkg::*; #(
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int SLOT_BITS = DEF_SLOT_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [META_W-1:0]     cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [19:0] address, [40:20] byte_count, [46:41] entry_data, [47] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  wire logic [MODE_W-1:0]     s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [5:0] size_log2, [25:6] object_base, [31:26] zero
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic      [STATUS_W-1:0]   m_axis_tuser
);

  dp_cmd_e            cmd;
  dp_status_t         dp_status;
  logic [ENTRY_W-1:0] size_log2;
  logic [ADDR_W-1:0]  object_base;

  bbst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (dp_status)
  );

  bbst_datapath #(
    .ADDR_BITS (ADDR_BITS),
    .SLOT_BITS (SLOT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_mode_i         (s_axis_tuser),
    .in_address_i      (s_axis_tdata[19:0]),
    .in_byte_count_i   (s_axis_tdata[40:20]),
    .in_entry_data_i   (s_axis_tdata[46:41]),
    .out_status_o      (m_axis_tuser),
    .out_size_log2_o   (size_log2),
    .out_object_base_o (object_base)
  );

  assign m_axis_tdata = {6'b0, object_base, size_log2};

endmodule

`default_nettype wire

// ===== hdl/bbst_checker.sv =====
// Port-level assertion checker for the size table unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bbst_checker import bbst_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [STATUS_W-1:0]   m_axis_tuser
);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in work")
  `ASSERT_IMP(a_empty_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == STAT_EMPTY, m_axis_tdata == '0, "empty result carries data")
  `ASSERT_IMP(a_large_nobase, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == STAT_TOO_LARGE, m_axis_tdata[25:6] == '0, "oversize result carries a base")

endmodule

bind baggy_bounds_size_table_unit bbst_checker u_bbst_checker (.*);

`default_nettype wire
